>>> hdl/avc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package avc_pkg;
  localparam int CoordW = 16;
  localparam int DiffW  = 17;
  localparam int RotW   = 18;
  localparam int SqW    = 36;
  localparam int NormW  = 18;
  localparam int NumW   = 26;
  localparam int QuotW  = 26;
  localparam int OutW   = 17;
  localparam int LenW   = 8;
  localparam logic [LenW-1:0] LenReset = 8'd32;
  localparam logic signed [9:0] RotCos = 10'sd243;
  localparam logic signed [9:0] RotSin = -10'sd79;

  // Signed divide by 256, truncating toward zero
  function automatic logic signed [RotW-1:0] div256(input logic signed [27:0] p);
    logic signed [27:0] a;
    begin
      a = p + (p[27] ? 28'sd255 : 28'sd0);
      div256 = RotW'(a >>> 8);
    end
  endfunction

  // One element that flows through the divider pipeline
  typedef struct packed {
    logic                    vld;
    logic [3:0][NumW-1:0]    mag;   // |numerator| remainders become partial state
    logic [3:0]              neg;
    logic [3:0][QuotW-1:0]   quo;
    logic [3:0][NumW:0]      rem;
    logic [NormW-1:0]        den;
    logic signed [CoordW-1:0] tx;
    logic signed [CoordW-1:0] ty;
  } div_stage_t;
endpackage
`default_nettype wire

>>> hdl/avc_front.sv
`timescale 1ns / 1ps
`default_nettype none
// Reverse vector, rotation, squared length
module avc_front (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 vld_i,
  input  wire logic signed [avc_pkg::CoordW-1:0]    tip_x,
  input  wire logic signed [avc_pkg::CoordW-1:0]    tip_y,
  input  wire logic signed [avc_pkg::CoordW-1:0]    tail_x,
  input  wire logic signed [avc_pkg::CoordW-1:0]    tail_y,
  output logic                                      vld_o,
  output logic signed [avc_pkg::DiffW-1:0]          rx_o,
  output logic signed [avc_pkg::DiffW-1:0]          ry_o,
  output logic signed [avc_pkg::RotW-1:0]           ox_o,
  output logic signed [avc_pkg::RotW-1:0]           oy_o,
  output logic [avc_pkg::SqW-1:0]                   sq_o,
  output logic signed [avc_pkg::CoordW-1:0]         tx_o,
  output logic signed [avc_pkg::CoordW-1:0]         ty_o
);
  localparam int DiffW = avc_pkg::DiffW;
  localparam int SqW = avc_pkg::SqW;

  logic v1_r, v2_r, v3_r, v4_r;
  logic signed [avc_pkg::DiffW-1:0] rx1_r, ry1_r, rx2_r, ry2_r, rx3_r, ry3_r, rx4_r, ry4_r;
  logic signed [avc_pkg::CoordW-1:0] tx1_r, ty1_r, tx2_r, ty2_r, tx3_r, ty3_r, tx4_r, ty4_r;
  logic signed [27:0] pxc_r, pxs_r, pyc_r, pys_r;
  logic signed [avc_pkg::RotW-1:0] ox2_r, oy2_r, ox3_r, oy3_r;
  logic [avc_pkg::SqW-1:0] sq3_r;
  logic signed [avc_pkg::RotW-1:0] ox_nxt, oy_nxt;

  always_comb begin
    ox_nxt = avc_pkg::div256(pxc_r) - avc_pkg::div256(pys_r);
    oy_nxt = avc_pkg::div256(pxs_r) + avc_pkg::div256(pyc_r);
  end

  // products, rotation and squares follow the difference as successive register stages
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0; v2_r <= 1'b0; v3_r <= 1'b0; v4_r <= 1'b0;
    end else begin
      v1_r <= vld_i; v2_r <= v1_r; v3_r <= v2_r; v4_r <= v3_r;
    end
    rx1_r <= DiffW'(tail_x) - DiffW'(tip_x);
    ry1_r <= DiffW'(tail_y) - DiffW'(tip_y);
    tx1_r <= tip_x; ty1_r <= tip_y;
    pxc_r <= 28'(rx1_r * avc_pkg::RotCos);
    pxs_r <= 28'(rx1_r * avc_pkg::RotSin);
    pyc_r <= 28'(ry1_r * avc_pkg::RotCos);
    pys_r <= 28'(ry1_r * avc_pkg::RotSin);
    rx2_r <= rx1_r; ry2_r <= ry1_r; tx2_r <= tx1_r; ty2_r <= ty1_r;
    ox2_r <= ox_nxt; oy2_r <= oy_nxt;
    rx3_r <= rx2_r; ry3_r <= ry2_r; tx3_r <= tx2_r; ty3_r <= ty2_r;
    ox3_r <= ox2_r; oy3_r <= oy2_r;
    sq3_r <= SqW'(ox2_r * ox2_r) + SqW'(oy2_r * oy2_r);
    rx4_r <= rx3_r; ry4_r <= ry3_r; tx4_r <= tx3_r; ty4_r <= ty3_r;
  end

  assign vld_o = v4_r;
  assign rx_o = rx4_r; assign ry_o = ry4_r;
  assign ox_o = ox3_r; assign oy_o = oy3_r;
  assign sq_o = sq3_r; assign tx_o = tx4_r; assign ty_o = ty4_r;
endmodule
`default_nettype wire

>>> hdl/avc_sqrt.sv
`timescale 1ns / 1ps
`default_nettype none
// Pipelined restoring square root, one result bit per stage
module avc_sqrt (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         vld_i,
  input  wire logic [avc_pkg::SqW-1:0]      sq_i,
  input  wire logic [63:0]                  side_i,
  output logic                              vld_o,
  output logic [avc_pkg::NormW-1:0]         root_o,
  output logic [63:0]                       side_o
);
  localparam int N = avc_pkg::NormW;
  localparam int SqW = avc_pkg::SqW;
  logic                v_r   [N+1];
  logic [SqW-1:0]      rad_r [N+1];
  logic [N-1:0]        rt_r  [N+1];
  logic [N+1:0]        rm_r  [N+1];
  logic [63:0]         sd_r  [N+1];

  assign v_r[0] = vld_i;
  assign rad_r[0] = sq_i;
  assign rt_r[0] = '0;
  assign rm_r[0] = '0;
  assign sd_r[0] = side_i;

  for (genvar i = 0; i < N; i++) begin : g_st
    logic [N+1:0] trial, rm_sh;
    logic v_q;
    logic [SqW-1:0] rad_q;
    logic [N-1:0] rt_q;
    logic [N+1:0] rm_q;
    logic [63:0] sd_q;
    always_comb begin
      rm_sh = {rm_r[i][N-1:0], rad_r[i][SqW-1 -: 2]};
      trial = {rt_r[i], 2'b01};
    end
    always_ff @(posedge clk) begin
      if (!rst_n) v_q <= 1'b0;
      else v_q <= v_r[i];
      rad_q <= {rad_r[i][SqW-3:0], 2'b00};
      sd_q <= sd_r[i];
      if (rm_sh >= trial) begin
        rm_q <= rm_sh - trial;
        rt_q <= {rt_r[i][N-2:0], 1'b1};
      end else begin
        rm_q <= rm_sh;
        rt_q <= {rt_r[i][N-2:0], 1'b0};
      end
    end
    assign v_r[i+1] = v_q;
    assign rad_r[i+1] = rad_q;
    assign rt_r[i+1] = rt_q;
    assign rm_r[i+1] = rm_q;
    assign sd_r[i+1] = sd_q;
  end

  assign vld_o = v_r[N];
  assign root_o = rt_r[N];
  assign side_o = sd_r[N];
endmodule
`default_nettype wire

>>> hdl/avc_div.sv
`timescale 1ns / 1ps
`default_nettype none
// Four lane pipelined restoring divider, one quotient bit per stage
module avc_div (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire avc_pkg::div_stage_t          in_i,
  output avc_pkg::div_stage_t               out_o
);
  localparam int Q = avc_pkg::QuotW;
  avc_pkg::div_stage_t st [Q+1];

  assign st[0] = in_i;
  for (genvar i = 0; i < Q; i++) begin : g_st
    avc_pkg::div_stage_t nx, q_r;
    always_comb begin
      nx = st[i];
      for (int l = 0; l < 4; l++) begin
        logic [avc_pkg::NumW:0] sh;
        sh = {st[i].rem[l][avc_pkg::NumW-1:0], st[i].mag[l][avc_pkg::NumW-1]};
        nx.mag[l] = {st[i].mag[l][avc_pkg::NumW-2:0], 1'b0};
        if (sh >= (avc_pkg::NumW+1)'(st[i].den)) begin
          nx.rem[l] = sh - (avc_pkg::NumW+1)'(st[i].den);
          nx.quo[l] = {st[i].quo[l][Q-2:0], 1'b1};
        end else begin
          nx.rem[l] = sh;
          nx.quo[l] = {st[i].quo[l][Q-2:0], 1'b0};
        end
      end
    end
    always_ff @(posedge clk) begin
      if (!rst_n) q_r.vld <= 1'b0;
      else q_r.vld <= nx.vld;
      q_r.mag <= nx.mag; q_r.neg <= nx.neg; q_r.quo <= nx.quo;
      q_r.rem <= nx.rem; q_r.den <= nx.den; q_r.tx <= nx.tx; q_r.ty <= nx.ty;
    end
    assign st[i+1] = q_r;
  end
  assign out_o = st[Q];
endmodule
`default_nettype wire

>>> hdl/arrowhead_vertex_calc.sv
`timescale 1ns / 1ps
`default_nettype none
// Arrowhead vertex calculator. A request is taken on any cycle with start high
// (busy is always low), and its result appears on the out_ ports with out_valid
// for one cycle; one request per cycle is sustained. The path runs through the
// bit-per-stage square root (18 stages) and the four-lane divider (26 stages). The
// receiver cannot stall the output. The user must write arrow_length through
// cfg_valid/cfg_ready only while no request is in flight; the block does not enforce it.
module arrowhead_vertex_calc (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              start,
  output logic                                   busy,
  input  wire logic signed [15:0]                in_tip_x,
  input  wire logic signed [15:0]                in_tip_y,
  input  wire logic signed [15:0]                in_tail_x,
  input  wire logic signed [15:0]                in_tail_y,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [7:0]                        cfg_arrow_length,
  output logic                                   out_valid,
  output logic signed [16:0]                     out_edge_x,
  output logic signed [16:0]                     out_edge_y,
  output logic signed [16:0]                     out_back_x,
  output logic signed [16:0]                     out_back_y,
  output logic                                   out_degenerate
);
  localparam int NumW = avc_pkg::NumW;
  logic [avc_pkg::LenW-1:0] len_r;
  logic fv;
  logic signed [16:0] rx, ry;
  logic signed [17:0] ox, oy;
  logic [35:0] sq;
  logic signed [15:0] tx, ty;
  logic sv;
  logic [17:0] root;
  logic [63:0] side_i, side_o;
  // numerator stage
  logic m_v_r;
  logic signed [NumW-1:0] m_n_r [4];
  logic [17:0] m_den_r;
  logic signed [15:0] m_tx_r, m_ty_r;
  avc_pkg::div_stage_t d_in, d_out;
  logic o_v_r, o_dg_r;
  logic signed [16:0] o_ex_r, o_ey_r, o_bx_r, o_by_r;
  logic signed [NumW-1:0] q [4];

  assign busy = 1'b0;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) len_r <= avc_pkg::LenReset;
    else if (cfg_valid && cfg_ready) len_r <= cfg_arrow_length;
  end

  avc_front u_front (
    .clk(clk), .rst_n(rst_n), .vld_i(start && !busy),
    .tip_x(in_tip_x), .tip_y(in_tip_y), .tail_x(in_tail_x), .tail_y(in_tail_y),
    .vld_o(fv), .rx_o(rx), .ry_o(ry), .ox_o(ox), .oy_o(oy), .sq_o(sq),
    .tx_o(tx), .ty_o(ty)
  );

  assign side_i = {rx, ry, ox[16:0], tx[12:0]};
  // ox sign bit, tx upper bits, ty and oy don't fit; carry rest in parallel shift line
  localparam int SqD = avc_pkg::NormW;
  logic [SqD-1:0][37:0] aux_r;
  logic [37:0] aux_in;
  assign aux_in = {ox[17], oy, tx[15:13], ty};
  always_ff @(posedge clk) begin
    aux_r[0] <= aux_in;
    for (int i = 1; i < SqD; i++) aux_r[i] <= aux_r[i-1];
  end

  avc_sqrt u_sqrt (
    .clk(clk), .rst_n(rst_n), .vld_i(fv), .sq_i(sq), .side_i(side_i),
    .vld_o(sv), .root_o(root), .side_o(side_o)
  );

  logic signed [16:0] s_rx, s_ry;
  logic signed [15:0] s_tx, s_ty;
  logic signed [17:0] s_ox18, s_oy18;
  always_comb begin
    s_rx = side_o[63:47];
    s_ry = side_o[46:30];
    s_ox18 = {aux_r[SqD-1][37], side_o[29:13]};
    s_oy18 = aux_r[SqD-1][36:19];
    s_tx = {aux_r[SqD-1][18:16], side_o[12:0]};
    s_ty = aux_r[SqD-1][15:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) m_v_r <= 1'b0;
    else m_v_r <= sv;
    m_n_r[0] <= NumW'(s_ox18 * $signed({1'b0, len_r}));
    m_n_r[1] <= NumW'(s_oy18 * $signed({1'b0, len_r}));
    m_n_r[2] <= NumW'(s_rx * $signed({1'b0, len_r}));
    m_n_r[3] <= NumW'(s_ry * $signed({1'b0, len_r}));
    m_den_r <= root;
    m_tx_r <= s_tx; m_ty_r <= s_ty;
  end

  always_comb begin
    d_in = '0;
    d_in.vld = m_v_r;
    d_in.den = m_den_r;
    d_in.tx = m_tx_r;
    d_in.ty = m_ty_r;
    for (int l = 0; l < 4; l++) begin
      d_in.neg[l] = m_n_r[l][NumW-1];
      d_in.mag[l] = m_n_r[l][NumW-1] ? NumW'(-m_n_r[l]) : NumW'(m_n_r[l]);
    end
  end

  avc_div u_div (.clk(clk), .rst_n(rst_n), .in_i(d_in), .out_o(d_out));

  always_comb begin
    for (int l = 0; l < 4; l++)
      q[l] = d_out.neg[l] ? -$signed(d_out.quo[l]) : $signed(d_out.quo[l]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) o_v_r <= 1'b0;
    else o_v_r <= d_out.vld;
    o_dg_r <= (d_out.den == '0);
    if (d_out.den == '0) begin
      o_ex_r <= 17'(d_out.tx); o_bx_r <= 17'(d_out.tx);
      o_ey_r <= 17'(d_out.ty); o_by_r <= 17'(d_out.ty);
    end else begin
      o_ex_r <= 17'(d_out.tx) + 17'(q[0]);
      o_ey_r <= 17'(d_out.ty) + 17'(q[1]);
      o_bx_r <= 17'(d_out.tx) + 17'(q[2]);
      o_by_r <= 17'(d_out.ty) + 17'(q[3]);
    end
  end

  assign out_valid = o_v_r;
  assign out_edge_x = o_ex_r;
  assign out_edge_y = o_ey_r;
  assign out_back_x = o_bx_r;
  assign out_back_y = o_by_r;
  assign out_degenerate = o_dg_r;

  a_busy_low: assert property (@(posedge clk) disable iff (!rst_n) !busy)
    else $error("busy asserted");
  a_degen_tip: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_degenerate |-> out_edge_x == out_back_x && out_edge_y == out_back_y)
    else $error("degenerate vertices differ");
  a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n) cfg_ready)
    else $error("cfg_ready dropped");
endmodule
`default_nettype wire
